/* hdl/whe_pkg.sv */
`timescale 1ns / 1ps

package whe_pkg;

  // Default geometry and fixed-point format.
  localparam int MAX_BINS_DEF  = 16;
  localparam int FRAC_BITS_DEF = 16;

  // Field widths.
  localparam int ACT_W      = 3;
  localparam int CHAN_W     = 8;
  localparam int WEIGHT_W   = 17;
  localparam int BINREG_W   = 5;
  localparam int RANGE_W    = 9;
  localparam int VALUE_W    = 32;
  localparam int ADDR_OUT_W = 12;
  localparam int STATUS_W   = 2;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
  localparam logic [ACT_W-1:0] ACT_NORM   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 3'd3;
  localparam logic [ACT_W-1:0] ACT_XFORM  = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_SAT  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_SKIP = 2'd2;

  // Configuration register indexes and reset values.
  localparam logic REG_BINS  = 1'b0;
  localparam logic REG_RANGE = 1'b1;
  localparam logic [BINREG_W-1:0] BINS_RST  = 5'd16;
  localparam logic [RANGE_W-1:0]  RANGE_RST = 9'd256;

  // Divider status seen by the controller.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* hdl/whe_div.sv */
`timescale 1ns / 1ps

module whe_div import whe_pkg::*; #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 44
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output div_stat_t        stat_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q, rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DEN_W:0]   rem_sh;
  logic             fits;

  // One restoring step per cycle; the dividend shifts out as the quotient shifts in.
  always_comb begin
    rem_sh = {rem_q, num_q[NUM_W-1]};
    fits   = (rem_sh >= {1'b0, den_q});
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(NUM_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
      num_d = {num_q[NUM_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand registers.
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = num_q;

endmodule

/* hdl/whe_store.sv */
`timescale 1ns / 1ps

module whe_store #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12,
  parameter int DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Bin memory with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/weighted_color_histogram_engine_top.sv */
`timescale 1ns / 1ps

// Weighted 3D color histogram engine.
// Items enter on the s_axis channel (action, three channel values, weight; the
// weight flag in tuser, end of batch in tlast). Each item gives exactly one
// result beat on m_axis: bin value and flat bin address in tdata, status in tuser.
// Configuration writes (index 0 bins per channel, 1 value range) use the cfg
// channel and are taken only while the engine is idle; each write recomputes
// the bin width with the shared divider.
// Lookup and insert quantize the three channel values in turn through the
// shared bit-serial divider; an insert with tlast set then normalizes too.
// Normalize walks the active bins twice: first to sum them, then to divide
// each by the sum (an all-zero sum skips this with skip status). Transform
// walks twice as well, to find the smallest nonzero bin, then to divide it
// by each nonzero bin, with empty bins set to one. Clear takes one cycle
// per memory entry. Only one item is in work; the engine idles between items.
// After reset the engine sweeps the whole bin memory to zero (MAX_BINS^3
// entries) and computes the bin width before it raises s_axis_tready.
// A stalled receiver holds the result in the output register; the next item
// may still be accepted, but its result waits until the register is free.
module weighted_color_histogram_engine_top import whe_pkg::*; #(
  parameter int MAX_BINS_PER_CHANNEL = MAX_BINS_DEF,
  parameter int BIN_FRACTION_BITS    = FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // action[2:0], chan_a[10:3], chan_b[18:11], chan_c[26:19], pixel_weight[43:27]
  input  logic [47:0]         s_axis_tdata,
  // use_weight[0]
  input  logic                s_axis_tuser,
  input  logic                s_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // bin_value[31:0], bin_address[43:32]
  output logic [47:0]         m_axis_tdata,
  // status[1:0]
  output logic [STATUS_W-1:0] m_axis_tuser,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [RANGE_W-1:0]  cfg_data_i
);

  localparam int MAXB   = MAX_BINS_PER_CHANNEL;
  localparam int F      = BIN_FRACTION_BITS;
  localparam int BW     = $clog2(MAXB + 1);
  localparam int LW     = $clog2(MAXB);
  localparam int AW     = 3 * LW;
  localparam int DEPTH  = MAXB * MAXB * MAXB;
  localparam int CW     = AW + 1;
  localparam int SUM_W  = VALUE_W + AW;
  localparam int NUM_W  = VALUE_W + F;
  localparam int WSH    = 24 - F;
  localparam logic [VALUE_W-1:0] ONE_FIX = VALUE_W'(1) << F;

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_WDIV  = 5'd1;
  localparam logic [4:0] S_WWAIT = 5'd2;
  localparam logic [4:0] S_IDLE  = 5'd3;
  localparam logic [4:0] S_QDIV  = 5'd4;
  localparam logic [4:0] S_QWAIT = 5'd5;
  localparam logic [4:0] S_ADDR1 = 5'd6;
  localparam logic [4:0] S_ADDR2 = 5'd7;
  localparam logic [4:0] S_RMW   = 5'd8;
  localparam logic [4:0] S_SRD   = 5'd9;
  localparam logic [4:0] S_SACC  = 5'd10;
  localparam logic [4:0] S_SCHK  = 5'd11;
  localparam logic [4:0] S_NRD   = 5'd12;
  localparam logic [4:0] S_NDIV  = 5'd13;
  localparam logic [4:0] S_NWAIT = 5'd14;
  localparam logic [4:0] S_MRD   = 5'd15;
  localparam logic [4:0] S_MACC  = 5'd16;
  localparam logic [4:0] S_XRD   = 5'd17;
  localparam logic [4:0] S_XDIV  = 5'd18;
  localparam logic [4:0] S_XWAIT = 5'd19;
  localparam logic [4:0] S_FRD   = 5'd20;
  localparam logic [4:0] S_FGET  = 5'd21;
  localparam logic [4:0] S_DONE  = 5'd22;

  logic [4:0]          state_q;
  logic                init_q;
  logic [BINREG_W-1:0] bins_q;
  logic [RANGE_W-1:0]  range_q;
  logic [RANGE_W-1:0]  wid_q;
  logic [2*BW-1:0]     bb_q;
  logic [CW-1:0]       n_q;
  logic [ACT_W-1:0]    act_q;
  logic [CHAN_W-1:0]   chan_q [3];
  logic [WEIGHT_W-1:0] wgt_q;
  logic                usew_q, eob_q;
  logic [1:0]          qi_q;
  logic [BW-1:0]       qv_q [3];
  logic [AW-1:0]       t_q, id_q;
  logic [CW-1:0]       cnt_q;
  logic [SUM_W-1:0]    sum_q;
  logic [VALUE_W-1:0]  min_q, val_q;
  logic [STATUS_W-1:0] stat_q;
  logic                out_valid_q;
  logic [47:0]         out_data_q;
  logic [STATUS_W-1:0] out_user_q;

  logic [BW-1:0]       b_eff;
  logic                last_walk, last_clr;
  logic [CW-1:0]       cnt_inc;
  logic                div_start;
  logic [NUM_W-1:0]    div_num, div_quot;
  logic [SUM_W-1:0]    div_den;
  div_stat_t           div_stat;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [VALUE_W-1:0]  mem_wdata, rdata;
  logic [VALUE_W:0]    w_ext, acc;
  logic [24:0]         w_wide;
  logic [AW+11:0]      addr_wide;
  logic                out_load, pix_act;

  // Effective bin count: zero reads as one, large values clamp to the maximum.
  always_comb begin
    if (bins_q == '0) begin
      b_eff = BW'(1);
    end else if (int'(bins_q) > MAXB) begin
      b_eff = BW'(MAXB);
    end else begin
      b_eff = BW'(bins_q);
    end
  end

  // Walk bookkeeping.
  assign cnt_inc   = cnt_q + 1'b1;
  assign last_walk = (cnt_inc == n_q);
  assign last_clr  = (cnt_q == CW'(DEPTH - 1));

  // Weight added on insert, aligned to the bin fraction.
  assign w_wide = {wgt_q, 8'b0} >> WSH;
  assign w_ext  = usew_q ? (VALUE_W + 1)'(w_wide) : {1'b0, ONE_FIX};
  assign acc    = {1'b0, rdata} + w_ext;

  // Divider operand selection.
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_q)
      S_WDIV: begin
        div_start = 1'b1;
        div_num   = NUM_W'(range_q);
        div_den   = SUM_W'(b_eff);
      end
      S_QDIV: begin
        div_start = 1'b1;
        div_num   = NUM_W'(chan_q[qi_q]);
        div_den   = SUM_W'(wid_q);
      end
      S_NDIV: begin
        div_start = 1'b1;
        div_num   = {rdata, F'(0)};
        div_den   = sum_q;
      end
      S_XDIV: begin
        div_start = (rdata != '0);
        div_num   = {min_q, F'(0)};
        div_den   = SUM_W'(rdata);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Memory port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_q[AW-1:0];
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = cnt_q[AW-1:0];
    unique case (state_q)
      S_CLR: begin
        mem_we = 1'b1;
      end
      S_ADDR2: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(t_q * b_eff + qv_q[2]);
      end
      S_RMW: begin
        mem_we    = (act_q == ACT_INSERT);
        mem_waddr = id_q;
        mem_wdata = acc[VALUE_W] ? '1 : acc[VALUE_W-1:0];
      end
      S_SRD, S_NRD, S_MRD, S_XRD: begin
        mem_re = 1'b1;
      end
      S_NWAIT: begin
        mem_we    = div_stat.done;
        mem_wdata = div_quot[VALUE_W-1:0];
      end
      S_XDIV: begin
        mem_we    = (rdata == '0);
        mem_wdata = ONE_FIX;
      end
      S_XWAIT: begin
        mem_we    = div_stat.done;
        mem_wdata = (div_quot > NUM_W'(ONE_FIX)) ? ONE_FIX : div_quot[VALUE_W-1:0];
      end
      S_FRD: begin
        mem_re    = 1'b1;
        mem_raddr = id_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign pix_act  = (act_q == ACT_INSERT) || (act_q == ACT_LOOKUP);
  assign out_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);
  assign addr_wide = {12'b0, id_q};

  // Main sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      init_q      <= 1'b1;
      bins_q      <= BINS_RST;
      range_q     <= RANGE_RST;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      wid_q       <= '0;
      bb_q        <= '0;
      n_q         <= '0;
      act_q       <= ACT_CLEAR;
      stat_q      <= STAT_OK;
      qi_q        <= '0;
      sum_q       <= '0;
      min_q       <= ONE_FIX;
      val_q       <= '0;
      t_q         <= '0;
      id_q        <= '0;
      wgt_q       <= '0;
      usew_q      <= 1'b0;
      eob_q       <= 1'b0;
      out_data_q  <= '0;
      out_user_q  <= STAT_OK;
      for (int i = 0; i < 3; i++) begin
        chan_q[i] <= '0;
        qv_q[i]   <= '0;
      end
    end else begin
      if (m_axis_tready && out_valid_q && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLR: begin
          if (last_clr) begin
            cnt_q   <= '0;
            init_q  <= 1'b0;
            state_q <= init_q ? S_WDIV : S_DONE;
          end else begin
            cnt_q <= cnt_inc;
          end
        end
        S_WDIV: begin
          bb_q    <= b_eff * b_eff;
          state_q <= S_WWAIT;
        end
        S_WWAIT: begin
          if (div_stat.done) begin
            wid_q   <= (div_quot == '0) ? RANGE_W'(1) : div_quot[RANGE_W-1:0];
            n_q     <= CW'(bb_q * b_eff);
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cfg_valid_i) begin
            if (cfg_index_i == REG_BINS) begin
              bins_q <= cfg_data_i[BINREG_W-1:0];
            end else begin
              range_q <= cfg_data_i;
            end
            state_q <= S_WDIV;
          end else if (s_axis_tvalid) begin
            act_q     <= s_axis_tdata[2:0];
            chan_q[0] <= s_axis_tdata[10:3];
            chan_q[1] <= s_axis_tdata[18:11];
            chan_q[2] <= s_axis_tdata[26:19];
            wgt_q     <= s_axis_tdata[43:27];
            usew_q    <= s_axis_tuser;
            eob_q     <= s_axis_tlast;
            stat_q    <= STAT_OK;
            cnt_q     <= '0;
            qi_q      <= '0;
            sum_q     <= '0;
            min_q     <= ONE_FIX;
            unique case (s_axis_tdata[2:0]) inside
              ACT_CLEAR:              state_q <= S_CLR;
              ACT_INSERT, ACT_LOOKUP: state_q <= S_QDIV;
              ACT_NORM:               state_q <= S_SRD;
              ACT_XFORM:              state_q <= S_MRD;
              default:                state_q <= S_DONE;
            endcase
          end
        end
        S_QDIV: begin
          state_q <= S_QWAIT;
        end
        S_QWAIT: begin
          if (div_stat.done) begin
            qv_q[qi_q] <= (div_quot > NUM_W'(b_eff - 1'b1)) ? b_eff - 1'b1 : BW'(div_quot);
            qi_q       <= qi_q + 1'b1;
            state_q    <= (qi_q == 2'd2) ? S_ADDR1 : S_QDIV;
          end
        end
        S_ADDR1: begin
          t_q     <= AW'(qv_q[0] * b_eff + qv_q[1]);
          state_q <= S_ADDR2;
        end
        S_ADDR2: begin
          id_q    <= mem_raddr;
          state_q <= S_RMW;
        end
        S_RMW: begin
          if (act_q == ACT_INSERT) begin
            val_q  <= mem_wdata;
            stat_q <= acc[VALUE_W] ? STAT_SAT : STAT_OK;
            state_q <= eob_q ? S_SRD : S_DONE;
          end else begin
            val_q   <= rdata;
            state_q <= S_DONE;
          end
        end
        S_SRD: begin
          state_q <= S_SACC;
        end
        S_SACC: begin
          sum_q <= sum_q + SUM_W'(rdata);
          if (last_walk) begin
            cnt_q   <= '0;
            state_q <= S_SCHK;
          end else begin
            cnt_q   <= cnt_inc;
            state_q <= S_SRD;
          end
        end
        S_SCHK: begin
          if (sum_q == '0) begin
            stat_q  <= STAT_SKIP;
            state_q <= (act_q == ACT_INSERT) ? S_FRD : S_DONE;
          end else begin
            state_q <= S_NRD;
          end
        end
        S_NRD: begin
          state_q <= S_NDIV;
        end
        S_NDIV: begin
          state_q <= S_NWAIT;
        end
        S_NWAIT: begin
          if (div_stat.done) begin
            if (last_walk) begin
              cnt_q   <= '0;
              state_q <= (act_q == ACT_INSERT) ? S_FRD : S_DONE;
            end else begin
              cnt_q   <= cnt_inc;
              state_q <= S_NRD;
            end
          end
        end
        S_MRD: begin
          state_q <= S_MACC;
        end
        S_MACC: begin
          if ((rdata != '0) && (rdata < min_q)) begin
            min_q <= rdata;
          end
          if (last_walk) begin
            cnt_q   <= '0;
            state_q <= S_XRD;
          end else begin
            cnt_q   <= cnt_inc;
            state_q <= S_MRD;
          end
        end
        S_XRD: begin
          state_q <= S_XDIV;
        end
        S_XDIV: begin
          if (rdata != '0) begin
            state_q <= S_XWAIT;
          end else if (last_walk) begin
            cnt_q   <= '0;
            state_q <= S_DONE;
          end else begin
            cnt_q   <= cnt_inc;
            state_q <= S_XRD;
          end
        end
        S_XWAIT: begin
          if (div_stat.done) begin
            if (last_walk) begin
              cnt_q   <= '0;
              state_q <= S_DONE;
            end else begin
              cnt_q   <= cnt_inc;
              state_q <= S_XRD;
            end
          end
        end
        S_FRD: begin
          state_q <= S_FGET;
        end
        S_FGET: begin
          val_q   <= rdata;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {4'b0, pix_act ? addr_wide[ADDR_OUT_W-1:0] : 12'b0,
                            pix_act ? val_q : 32'b0};
            out_user_q  <= stat_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  whe_div #(
    .NUM_W(NUM_W),
    .DEN_W(SUM_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .stat_o (div_stat),
    .quot_o (div_quot)
  );

  whe_store #(
    .DEPTH (DEPTH),
    .ADDR_W(AW),
    .DATA_W(VALUE_W)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_ready_o   = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef NO_ASSERTIONS
  // The divider is never restarted while a division is still running.
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy) else $error("divider restarted while busy");

  // Outside the clearing sweep, writes stay inside the active bins.
  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && (state_q != S_CLR)) |-> ({1'b0, mem_waddr} < n_q))
    else $error("bin write outside the active geometry");

  // A new result beat appears only from the completion state.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result raised outside completion");
`endif

endmodule
